@@ rtl/bfc_pkg.sv @@
// Shared widths, types and helpers of the box frustum cull block.
`default_nettype none

package bfc_pkg;

  // Positions are signed Q24.8. Matrix entries are signed Q4.12. The plane tests do not
  // depend on the scale, so the matrix fraction width never shows up in the logic.
  localparam int unsigned POS_FRAC_BITS = 8;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned ENT_W    = 16;
  localparam int unsigned ROW_BITS = 64;
  localparam int unsigned N_ROWS   = 4;
  localparam int unsigned N_AXES   = 3;
  localparam int unsigned ENT_OFF  = 3;    // entry that scales the constant 1.0
  localparam int unsigned N_PLANES = 6;

  // Rows of the matrix by the clip coordinate that they produce.
  localparam int unsigned AX_X = 0;
  localparam int unsigned AX_Y = 1;
  localparam int unsigned AX_Z = 2;
  localparam int unsigned AX_W = 3;

  // Entry times coordinate, the row sum at the center, one plane's coefficient on one
  // axis, one plane's value at the center, and the plane's largest value over the cube.
  localparam int unsigned PROD_W  = COORD_W + ENT_W;
  localparam int unsigned BASE_W  = PROD_W + 2;
  localparam int unsigned COEF_W  = PROD_W + 1;
  localparam int unsigned PLANE_W = BASE_W + 1;
  localparam int unsigned SUM_W   = PLANE_W + 2;

  // Queue between the front and the back; the depth must be a power of two.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_ROW3 = 3'd3
  } cfg_reg_e;

  // Identity matrix in Q4.12.
  localparam logic [ROW_BITS-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_BITS-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_BITS-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_BITS-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

  typedef logic [N_ROWS-1:0][ROW_BITS-1:0] matrix_t;

  // Word handed from the front to the back: the products with the center, the
  // products with the half size, and the offset entries of every row.
  typedef struct packed {
    logic [N_ROWS-1:0][N_AXES-1:0][PROD_W-1:0] cprod;
    logic [N_ROWS-1:0][N_AXES-1:0][PROD_W-1:0] hprod;
    logic [N_ROWS-1:0][ENT_W-1:0]              off;
  } prod_t;

  function automatic logic signed [ENT_W-1:0] mat_entry(input logic [ROW_BITS-1:0] row,
                                                        input int unsigned j);
    return $signed(row[ENT_W*j +: ENT_W]);
  endfunction

endpackage

`default_nettype wire

@@ rtl/bfc_cube_if.sv @@
// Input channel: one cube given by its center and half size.
`default_nettype none

interface bfc_cube_if;
  logic                                valid;
  logic                                ready;
  logic signed [bfc_pkg::COORD_W-1:0] center_x;
  logic signed [bfc_pkg::COORD_W-1:0] center_y;
  logic signed [bfc_pkg::COORD_W-1:0] center_z;
  logic signed [bfc_pkg::COORD_W-1:0] half_size;

  modport source (output valid, output center_x, output center_y, output center_z,
                  output half_size, input ready);
  modport sink (input valid, input center_x, input center_y, input center_z,
                input half_size, output ready);
endinterface

`default_nettype wire

@@ rtl/bfc_vis_if.sv @@
// Output channel: one visibility flag per cube.
`default_nettype none

interface bfc_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, output visible, input ready);
  modport sink (input valid, input visible, output ready);
endinterface

`default_nettype wire

@@ rtl/bfc_front.sv @@
// Front end: takes cubes, fixes the half size, and runs the multiplier bank.
`default_nettype none

module bfc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bfc_pkg::matrix_t matrix_i,
  bfc_cube_if.sink              cube_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bfc_pkg::prod_t        out_data_o
);

  // Stage A: registered cube.
  logic                                a_vld_q;
  logic signed [bfc_pkg::COORD_W-1:0] ctr_q [bfc_pkg::N_AXES];
  logic signed [bfc_pkg::COORD_W-1:0] half_q;
  logic signed [bfc_pkg::COORD_W-1:0] half_d;

  // Stage B: registered products.
  logic            b_vld_q;
  bfc_pkg::prod_t  prod_q;
  bfc_pkg::prod_t  prod_d;

  logic a_ready;
  logic b_ready;

  assign b_ready      = !b_vld_q || out_ready_i;
  assign a_ready      = !a_vld_q || b_ready;
  assign cube_i.ready = a_ready;

  // A half size of zero or less means one unit.
  always_comb begin
    if (cube_i.half_size <= 0) begin
      half_d = bfc_pkg::COORD_W'(1) << bfc_pkg::POS_FRAC_BITS;
    end else begin
      half_d = cube_i.half_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_ready) begin
      a_vld_q <= cube_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && cube_i.valid) begin
      ctr_q[0] <= cube_i.center_x;
      ctr_q[1] <= cube_i.center_y;
      ctr_q[2] <= cube_i.center_z;
      half_q   <= half_d;
    end
  end

  // Every product is formed exactly in PROD_W bits.
  always_comb begin
    logic signed [bfc_pkg::ENT_W-1:0]  ent;
    logic signed [bfc_pkg::PROD_W-1:0] ent_x;
    logic signed [bfc_pkg::PROD_W-1:0] ctr_x;
    logic signed [bfc_pkg::PROD_W-1:0] half_x;
    prod_d = '0;
    half_x = bfc_pkg::PROD_W'(half_q);
    for (int unsigned r = 0; r < bfc_pkg::N_ROWS; r++) begin
      for (int unsigned k = 0; k < bfc_pkg::N_AXES; k++) begin
        ent   = bfc_pkg::mat_entry(matrix_i[r], k);
        ent_x = bfc_pkg::PROD_W'(ent);
        ctr_x = bfc_pkg::PROD_W'(ctr_q[k]);
        prod_d.cprod[r][k] = ent_x * ctr_x;
        prod_d.hprod[r][k] = ent_x * half_x;
      end
      prod_d.off[r] = bfc_pkg::mat_entry(matrix_i[r], bfc_pkg::ENT_OFF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_ready) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_vld_q) begin
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = b_vld_q;
  assign out_data_o  = prod_q;

endmodule

`default_nettype wire

@@ rtl/bfc_fifo.sv @@
// Short queue of product words between the front and the back.
`default_nettype none

module bfc_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bfc_pkg::prod_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bfc_pkg::prod_t      out_data_o
);

  bfc_pkg::prod_t                  mem_q [bfc_pkg::FIFO_DEPTH];
  logic [bfc_pkg::PTR_W-1:0]       wr_ptr_q;
  logic [bfc_pkg::PTR_W-1:0]       rd_ptr_q;
  logic [bfc_pkg::CNT_W-1:0]       cnt_q;
  logic                            push;
  logic                            pop;

  assign in_ready_o  = cnt_q != bfc_pkg::CNT_W'(bfc_pkg::FIFO_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bfc_pkg::CNT_W'(bfc_pkg::FIFO_DEPTH))
    else $error("queue fill count beyond its depth");

  a_cnt_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue fill count missed a push");

  a_cnt_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue fill count missed a pop");

  a_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree while empty");
`endif

endmodule

`default_nettype wire

@@ rtl/bfc_back.sv @@
// Back end: row sums, plane terms, and the final visibility decision.
`default_nettype none

module bfc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bfc_pkg::prod_t in_data_i,
  bfc_vis_if.source           vis_o
);

  localparam int unsigned PL_LEFT   = 0;
  localparam int unsigned PL_RIGHT  = 1;
  localparam int unsigned PL_BOTTOM = 2;
  localparam int unsigned PL_TOP    = 3;
  localparam int unsigned PL_NEAR   = 4;
  localparam int unsigned PL_FAR    = 5;

  // Stage C: clip coordinates at the center, and the half-size terms.
  logic                                 c_vld_q;
  logic signed [bfc_pkg::BASE_W-1:0]    base_q [bfc_pkg::N_ROWS];
  logic signed [bfc_pkg::BASE_W-1:0]    base_d [bfc_pkg::N_ROWS];
  logic [bfc_pkg::N_ROWS-1:0][bfc_pkg::N_AXES-1:0][bfc_pkg::PROD_W-1:0] hc_q;

  // Stage D: per plane, its value at the center and the magnitudes of its axis terms.
  logic                                 d_vld_q;
  logic signed [bfc_pkg::PLANE_W-1:0]   pb_q [bfc_pkg::N_PLANES];
  logic signed [bfc_pkg::PLANE_W-1:0]   pb_d [bfc_pkg::N_PLANES];
  logic [bfc_pkg::COEF_W-1:0]           mag_q [bfc_pkg::N_PLANES][bfc_pkg::N_AXES];
  logic [bfc_pkg::COEF_W-1:0]           mag_d [bfc_pkg::N_PLANES][bfc_pkg::N_AXES];

  // Stage E: result word.
  logic e_vld_q;
  logic vis_q;
  logic vis_d;

  logic c_ready;
  logic d_ready;
  logic e_ready;

  assign e_ready    = !e_vld_q || vis_o.ready;
  assign d_ready    = !d_vld_q || e_ready;
  assign c_ready    = !c_vld_q || d_ready;
  assign in_ready_o = c_ready;

  always_comb begin
    for (int unsigned r = 0; r < bfc_pkg::N_ROWS; r++) begin
      base_d[r] = bfc_pkg::BASE_W'($signed(in_data_i.off[r])) <<< bfc_pkg::POS_FRAC_BITS;
      for (int unsigned k = 0; k < bfc_pkg::N_AXES; k++) begin
        base_d[r] = base_d[r] + bfc_pkg::BASE_W'($signed(in_data_i.cprod[r][k]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (c_ready) begin
      c_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      base_q <= base_d;
      hc_q   <= in_data_i.hprod;
    end
  end

  // Each plane value is linear in the corner, so over the cube it reaches its largest
  // value at the center plus the magnitudes of its three half-size terms. A plane culls
  // the cube exactly when that largest value is below zero.
  always_comb begin
    logic signed [bfc_pkg::PLANE_W-1:0] bx;
    logic signed [bfc_pkg::PLANE_W-1:0] by;
    logic signed [bfc_pkg::PLANE_W-1:0] bz;
    logic signed [bfc_pkg::PLANE_W-1:0] bw;
    logic signed [bfc_pkg::COEF_W-1:0]  hx;
    logic signed [bfc_pkg::COEF_W-1:0]  hy;
    logic signed [bfc_pkg::COEF_W-1:0]  hz;
    logic signed [bfc_pkg::COEF_W-1:0]  hw;
    logic signed [bfc_pkg::COEF_W-1:0]  coef [bfc_pkg::N_PLANES];
    bx = bfc_pkg::PLANE_W'(base_q[bfc_pkg::AX_X]);
    by = bfc_pkg::PLANE_W'(base_q[bfc_pkg::AX_Y]);
    bz = bfc_pkg::PLANE_W'(base_q[bfc_pkg::AX_Z]);
    bw = bfc_pkg::PLANE_W'(base_q[bfc_pkg::AX_W]);
    pb_d[PL_LEFT]   = bw + bx;
    pb_d[PL_RIGHT]  = bw - bx;
    pb_d[PL_BOTTOM] = bw + by;
    pb_d[PL_TOP]    = bw - by;
    pb_d[PL_NEAR]   = bz;
    pb_d[PL_FAR]    = bw - bz;
    for (int unsigned k = 0; k < bfc_pkg::N_AXES; k++) begin
      hx = bfc_pkg::COEF_W'($signed(hc_q[bfc_pkg::AX_X][k]));
      hy = bfc_pkg::COEF_W'($signed(hc_q[bfc_pkg::AX_Y][k]));
      hz = bfc_pkg::COEF_W'($signed(hc_q[bfc_pkg::AX_Z][k]));
      hw = bfc_pkg::COEF_W'($signed(hc_q[bfc_pkg::AX_W][k]));
      coef[PL_LEFT]   = hw + hx;
      coef[PL_RIGHT]  = hw - hx;
      coef[PL_BOTTOM] = hw + hy;
      coef[PL_TOP]    = hw - hy;
      coef[PL_NEAR]   = hz;
      coef[PL_FAR]    = hw - hz;
      for (int unsigned p = 0; p < bfc_pkg::N_PLANES; p++) begin
        mag_d[p][k] = coef[p][bfc_pkg::COEF_W-1] ? -coef[p] : coef[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (d_ready) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && c_vld_q) begin
      pb_q  <= pb_d;
      mag_q <= mag_d;
    end
  end

  always_comb begin
    logic [bfc_pkg::SUM_W-1:0]    peak;
    logic [bfc_pkg::N_PLANES-1:0] culled;
    for (int unsigned p = 0; p < bfc_pkg::N_PLANES; p++) begin
      peak = bfc_pkg::SUM_W'(pb_q[p]);
      for (int unsigned k = 0; k < bfc_pkg::N_AXES; k++) begin
        peak = peak + bfc_pkg::SUM_W'(mag_q[p][k]);
      end
      culled[p] = peak[bfc_pkg::SUM_W-1];
    end
    vis_d = ~|culled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (e_ready) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ready && d_vld_q) begin
      vis_q <= vis_d;
    end
  end

  assign vis_o.valid   = e_vld_q;
  assign vis_o.visible = vis_q;

endmodule

`default_nettype wire

@@ rtl/box_frustum_cull_clip_space_top.sv @@
// Top level of the box frustum cull: matrix registers, front end, queue and back end.
`default_nettype none

// Cube versus clip-space frustum cull with a zero-to-one depth range. Each input word
// gives a cube center and half size in signed Q24.8; a half size of zero or less is
// taken as 1.0. The cube is multiplied through the 4x4 view-projection matrix held in
// four 64-bit registers (signed Q4.12 entries, entry j of a row in bits 16j+15:16j, row 3
// giving w; reset loads the identity), and one output word reports visible = 0 when all
// eight corners lie strictly outside one plane (x < -w, x > w, y < -w, y > w, z < 0 or
// z > w), else visible = 1. Corners on a plane count as inside. All arithmetic is exact.
// Rather than transforming eight corners, the block uses linearity: each plane value at
// the center plus the magnitudes of its three half-size terms is its largest value over
// the cube. The block takes one cube per clock while the output is taken; the rate is set
// by the front end's bank of twenty-four 16x32 multipliers, which accept a new word every
// cycle. A result passes two front-end stages, the two-entry queue, and three back-end
// stages (row sums, plane terms, final sum and decision). The queue and the output
// register let the input keep flowing while a finished word waits to be taken. Matrix
// writes take effect on the next clock; the user must make them while no cube is in
// flight, which the block does not enforce. A write to an index past row 3 is ignored.
module box_frustum_cull_clip_space_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bfc_pkg::ROW_BITS-1:0]   cfg_data_i,
  bfc_cube_if.sink                             cube_i,
  bfc_vis_if.source                            vis_o
);

  bfc_pkg::matrix_t matrix_q;

  logic            fr_valid;
  logic            fr_ready;
  bfc_pkg::prod_t  fr_data;
  logic            bk_valid;
  logic            bk_ready;
  bfc_pkg::prod_t  bk_data;

  // Matrix registers; unused indexes fall through to the default arm.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q[0] <= bfc_pkg::ROW0_RST;
      matrix_q[1] <= bfc_pkg::ROW1_RST;
      matrix_q[2] <= bfc_pkg::ROW2_RST;
      matrix_q[3] <= bfc_pkg::ROW3_RST;
    end else if (cfg_we_i) begin
      unique case (bfc_pkg::cfg_reg_e'(cfg_idx_i))
        bfc_pkg::REG_ROW0: begin
          matrix_q[0] <= cfg_data_i;
        end
        bfc_pkg::REG_ROW1: begin
          matrix_q[1] <= cfg_data_i;
        end
        bfc_pkg::REG_ROW2: begin
          matrix_q[2] <= cfg_data_i;
        end
        bfc_pkg::REG_ROW3: begin
          matrix_q[3] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  bfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .matrix_i    (matrix_q),
    .cube_i      (cube_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  bfc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_data),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_data_o  (bk_data)
  );

  bfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bk_valid),
    .in_ready_o (bk_ready),
    .in_data_i  (bk_data),
    .vis_o      (vis_o)
  );

endmodule

`default_nettype wire
